// ===== design/kdlp_pkg.sv =====
// kdlp_pkg: shared types, key positions and sizes for the keypad debouncer
// with long-press detection; no dependencies, imported by every design file
package kdlp_pkg;

  localparam int BUF_DEPTH  = 16;
  localparam int FILL_W     = $clog2(BUF_DEPTH);
  localparam int NUM_DIGITS = 10;
  localparam int KEY_ENTER  = 10;
  localparam int KEY_CANCEL = 11;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [15:0] HOLD_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_CLR_ENTER  = 2'd1,
    FUNC_CLR_CANCEL = 2'd2,
    FUNC_CLR_DIGITS = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] key_status;
    logic [3:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic       entered;
    logic       entered_long;
    logic       cancelled;
    logic       cancelled_long;
    logic [3:0] digit_count;
    logic [3:0] read_digit;
    logic       digit_added;
  } out_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] digit;
  } digit_hit_t;

  // lowest newly pressed digit key
  function automatic digit_hit_t find_digit(input logic [NUM_DIGITS-1:0] rising);
    digit_hit_t hit;
    hit.found = 1'b0;
    hit.digit = '0;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      if (rising[k]) begin
        hit.found = 1'b1;
        hit.digit = 4'(k);
      end
    end
    return hit;
  endfunction

  // saturating hold counter, cleared on release
  function automatic logic [15:0] hold_update(input logic [15:0] count, input logic held);
    logic [15:0] nxt;
    if (!held) begin
      nxt = '0;
    end else if (count == HOLD_MAX) begin
      nxt = count;
    end else begin
      nxt = count + 16'd1;
    end
    return nxt;
  endfunction

endpackage

// ===== design/kdlp_core.sv =====
// kdlp_core: debounce state, hold counters, press flags and digit buffer;
// builds the result of the item being transferred in. depends on kdlp_pkg
module kdlp_core
  import kdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic      in_fire,
  input  in_item_t  in_item,
  output out_item_t res
);

  logic [15:0] long_press_ticks;
  logic [15:0] last_sample;
  logic [15:0] stable_prev;
  logic [15:0] enter_hold_count;
  logic [15:0] cancel_hold_count;
  logic        enter_flag;
  logic        enter_long;
  logic        cancel_flag;
  logic        cancel_long;
  logic [FILL_W-1:0]    digit_fill;
  logic [BUF_DEPTH-1:0] digit_vld;
  logic [3:0]           digit_mem [BUF_DEPTH];

  logic [15:0] enter_hold_next;
  logic [15:0] cancel_hold_next;
  logic        enter_flag_next;
  logic        enter_long_next;
  logic        cancel_flag_next;
  logic        cancel_long_next;
  logic [FILL_W-1:0] digit_fill_next;
  logic        stable_tick;
  logic [15:0] rising;
  digit_hit_t  hit;
  logic        add_digit;
  logic        clr_digits;
  logic [31:0] ridx_wide;
  logic [31:0] fill_wide;
  logic [FILL_W-1:0] rd_slot;
  logic        rd_in_range;
  logic [3:0]  rd_data;

  always_comb begin
    stable_tick      = (in_item.func == FUNC_TICK) && (in_item.key_status == last_sample);
    rising           = in_item.key_status & ~stable_prev;
    hit              = find_digit(rising[NUM_DIGITS-1:0]);
    add_digit        = stable_tick && hit.found;
    clr_digits       = (in_item.func == FUNC_CLR_DIGITS);

    enter_hold_next  = enter_hold_count;
    cancel_hold_next = cancel_hold_count;
    enter_flag_next  = enter_flag;
    enter_long_next  = enter_long;
    cancel_flag_next = cancel_flag;
    cancel_long_next = cancel_long;
    digit_fill_next  = digit_fill;

    unique case (in_item.func)
      FUNC_TICK: begin
        if (stable_tick) begin
          enter_hold_next  = hold_update(enter_hold_count, in_item.key_status[KEY_ENTER]);
          cancel_hold_next = hold_update(cancel_hold_count, in_item.key_status[KEY_CANCEL]);
          enter_flag_next  = rising[KEY_ENTER];
          cancel_flag_next = rising[KEY_CANCEL];
          enter_long_next  = enter_long || (enter_hold_next > long_press_ticks);
          cancel_long_next = cancel_long || (cancel_hold_next > long_press_ticks);
        end
      end
      FUNC_CLR_ENTER: begin
        enter_flag_next = 1'b0;
        enter_long_next = 1'b0;
      end
      FUNC_CLR_CANCEL: begin
        cancel_flag_next = 1'b0;
        cancel_long_next = 1'b0;
      end
      FUNC_CLR_DIGITS: begin
        digit_fill_next = '0;
      end
      default: begin
      end
    endcase

    if (add_digit) begin
      digit_fill_next = (32'(digit_fill) == BUF_DEPTH - 1) ? '0 : digit_fill + 1'b1;
    end

    // read sees this item's own write or clear
    ridx_wide   = 32'(in_item.read_index);
    rd_slot     = ridx_wide[FILL_W-1:0];
    rd_in_range = ridx_wide < BUF_DEPTH;
    if (!rd_in_range || clr_digits) begin
      rd_data = '0;
    end else if (add_digit && rd_slot == digit_fill) begin
      rd_data = hit.digit;
    end else if (digit_vld[rd_slot]) begin
      rd_data = digit_mem[rd_slot];
    end else begin
      rd_data = '0;
    end

    fill_wide          = 32'(digit_fill_next);
    res.entered        = enter_flag_next;
    res.entered_long   = enter_long_next;
    res.cancelled      = cancel_flag_next;
    res.cancelled_long = cancel_long_next;
    res.digit_count    = fill_wide[3:0];
    res.read_digit     = rd_data;
    res.digit_added    = add_digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks  <= LONG_PRESS_RESET;
      last_sample       <= '0;
      stable_prev       <= '0;
      enter_hold_count  <= '0;
      cancel_hold_count <= '0;
      enter_flag        <= 1'b0;
      enter_long        <= 1'b0;
      cancel_flag       <= 1'b0;
      cancel_long       <= 1'b0;
      digit_fill        <= '0;
      digit_vld         <= '0;
    end else begin
      if (cfg_wr_en) begin
        long_press_ticks <= cfg_wr_data;
      end
      if (in_fire) begin
        if (in_item.func == FUNC_TICK) begin
          last_sample <= in_item.key_status;
        end
        if (stable_tick) begin
          stable_prev <= in_item.key_status;
        end
        enter_hold_count  <= enter_hold_next;
        cancel_hold_count <= cancel_hold_next;
        enter_flag        <= enter_flag_next;
        enter_long        <= enter_long_next;
        cancel_flag       <= cancel_flag_next;
        cancel_long       <= cancel_long_next;
        digit_fill        <= digit_fill_next;
        if (clr_digits) begin
          digit_vld <= '0;
        end else if (add_digit) begin
          digit_vld[digit_fill] <= 1'b1;
        end
      end
    end
  end

  // slot data needs no reset, the valid bits cover it
  always_ff @(posedge clk) begin
    if (in_fire && add_digit) begin
      digit_mem[digit_fill] <= hit.digit;
    end
  end

`ifndef ASSERT_OFF
  a_clr_enter: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_item.func == FUNC_CLR_ENTER |=> !enter_flag && !enter_long)
    else $error("enter flags survived a clear");

  a_clr_digits: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_item.func == FUNC_CLR_DIGITS |=> digit_fill == '0 && digit_vld == '0)
    else $error("digit buffer not emptied by clear");

  a_add_marks: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.digit_added |=> digit_vld != '0 && !$stable(digit_fill))
    else $error("appended digit not recorded");
`endif

endmodule

// ===== design/kdlp_out_buf.sv =====
// kdlp_out_buf: result register plus one skid entry so a new item is
// transferred in while a finished result waits. depends on kdlp_pkg
module kdlp_out_buf
  import kdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty head");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("push into a full buffer");

  a_park_in_skid: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && out_stall |=> skid_valid && out_valid)
    else $error("result lost while head stalled");
`endif

endmodule

// ===== design/keypad_debounce_long_press.sv =====
// keypad_debounce_long_press: top level, joins the debounce core and the
// output buffer. depends on kdlp_pkg, kdlp_core, kdlp_out_buf
//
// Each transfer in produces exactly one result; a new item is taken every
// cycle while in_stall is low. The result sits in an output register backed
// by one skid entry; in_stall rises only while both are occupied, so a
// stalled consumer costs one extra item of slack before the input stalls.
// Results show the state after the item, including its own digit append
// or clear. long_press_ticks is written through cfg_wr_en / cfg_wr_data
// and resets to 100; the 16-slot digit buffer is empty after reset.
module keypad_debounce_long_press
  import kdlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic      in_fire;
  logic      buf_full;
  out_item_t res;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  kdlp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_item     (in_data),
    .res         (res)
  );

  kdlp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_keypad_debounce_long_press.sv =====
// tb_keypad_debounce_long_press: self-checking testbench for the keypad debouncer,
// predicting every result from its own model of the key, hold and digit state.
// depends on kdlp_pkg and keypad_debounce_long_press
module tb_keypad_debounce_long_press;
  import kdlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  keypad_debounce_long_press dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted keypad state
  logic [15:0]       long_ticks = LONG_PRESS_RESET;
  logic [15:0]       raw_keys = '0;
  logic [15:0]       stable_keys = '0;
  logic [15:0]       enter_hold = '0;
  logic [15:0]       cancel_hold = '0;
  logic              enter_flag = 1'b0;
  logic              enter_long = 1'b0;
  logic              cancel_flag = 1'b0;
  logic              cancel_long = 1'b0;
  logic [3:0]        digit_mem [BUF_DEPTH];
  logic [FILL_W-1:0] digit_fill = '0;

  out_item_t results_due [$];
  out_item_t due;
  int        mismatches = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  initial begin
    foreach (digit_mem[i]) digit_mem[i] = '0;
  end

  function automatic out_item_t keypad_next(in_item_t it);
    out_item_t   r;
    logic [15:0] rising;
    logic        added;
    int          k;
    added = 1'b0;
    case (it.func)
      FUNC_TICK: begin
        if (it.key_status == raw_keys) begin
          rising = it.key_status & ~stable_keys;
          for (k = 0; k < NUM_DIGITS; k++) begin
            if (!added && rising[k]) begin
              digit_mem[digit_fill] = 4'(k);
              digit_fill = digit_fill + 1'b1;
              added = 1'b1;
            end
          end
          enter_flag = rising[KEY_ENTER];
          cancel_flag = rising[KEY_CANCEL];
          if (!it.key_status[KEY_ENTER]) begin
            enter_hold = '0;
          end else if (enter_hold != 16'hFFFF) begin
            enter_hold = enter_hold + 16'd1;
          end
          if (enter_hold > long_ticks) enter_long = 1'b1;
          if (!it.key_status[KEY_CANCEL]) begin
            cancel_hold = '0;
          end else if (cancel_hold != 16'hFFFF) begin
            cancel_hold = cancel_hold + 16'd1;
          end
          if (cancel_hold > long_ticks) cancel_long = 1'b1;
          stable_keys = it.key_status;
        end
        raw_keys = it.key_status;
      end
      FUNC_CLR_ENTER: begin
        enter_flag = 1'b0;
        enter_long = 1'b0;
      end
      FUNC_CLR_CANCEL: begin
        cancel_flag = 1'b0;
        cancel_long = 1'b0;
      end
      FUNC_CLR_DIGITS: begin
        foreach (digit_mem[i]) digit_mem[i] = '0;
        digit_fill = '0;
      end
    endcase
    r.entered        = enter_flag;
    r.entered_long   = enter_long;
    r.cancelled      = cancel_flag;
    r.cancelled_long = cancel_long;
    r.digit_count    = 4'(digit_fill);
    r.read_digit     = digit_mem[it.read_index];
    r.digit_added    = added;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // a result moves at the next rising edge when valid and not stalled
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
      end else begin
        due = results_due.pop_front();
        check_field("entered", due.entered, out_data.entered);
        check_field("entered_long", due.entered_long, out_data.entered_long);
        check_field("cancelled", due.cancelled, out_data.cancelled);
        check_field("cancelled_long", due.cancelled_long, out_data.cancelled_long);
        check_field("digit_count", due.digit_count, out_data.digit_count);
        check_field("read_digit", due.read_digit, out_data.read_digit);
        check_field("digit_added", due.digit_added, out_data.digit_added);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(func_t f, logic [15:0] keys, logic [3:0] slot);
    in_item_t it;
    logic     taken;
    it.func = f;
    it.key_status = keys;
    it.read_index = slot;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    results_due.push_back(keypad_next(it));
  endtask

  task automatic tick_twice(logic [15:0] keys, logic [3:0] slot);
    send_item(FUNC_TICK, keys, slot);
    send_item(FUNC_TICK, keys, slot);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] ticks);
    wait_drain();
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    long_ticks = ticks;
  endtask

  task automatic test_directed();
    send_item(FUNC_TICK, 16'h0000, 4'd0);
    send_item(FUNC_TICK, 16'h0001, 4'd0);      // first sight of a key is unstable
    send_item(FUNC_TICK, 16'h0001, 4'd0);
    send_item(FUNC_TICK, 16'h0001, 4'd15);
    tick_twice(16'h0000, 4'd0);
    tick_twice(16'h0228, 4'd1);                // several digits, lowest wins
    tick_twice(16'h0C00, 4'd1);
    tick_twice(16'hFFFF, 4'd2);
    send_item(FUNC_CLR_ENTER, 16'hFFFF, 4'd2);
    send_item(FUNC_CLR_CANCEL, 16'h0000, 4'd1);
    tick_twice(16'h0000, 4'd3);
    tick_twice(16'h0200, 4'd3);
    send_item(FUNC_CLR_DIGITS, 16'hAAAA, 4'd15);
    send_item(FUNC_TICK, 16'h5555, 4'd0);
    send_item(FUNC_TICK, 16'hAAAA, 4'd0);
  endtask

  task automatic test_threshold_zero();
    set_threshold(16'd0);
    tick_twice(16'h0400, 4'd0);
    tick_twice(16'h0800, 4'd0);
    send_item(FUNC_CLR_ENTER, 16'h0000, 4'd0);
    send_item(FUNC_CLR_CANCEL, 16'h0000, 4'd0);
    tick_twice(16'h0000, 4'd0);
  endtask

  task automatic test_buffer_wrap();
    int i;
    set_threshold(LONG_PRESS_RESET);
    send_item(FUNC_CLR_DIGITS, 16'h0000, 4'd0);
    for (i = 0; i < 20; i++) begin
      tick_twice(16'h0000, 4'($urandom));
      tick_twice(16'(1 << (i % NUM_DIGITS)), 4'($urandom));
    end
    for (i = 0; i < BUF_DEPTH; i++) send_item(FUNC_TICK, 16'h0000, 4'(i));
  endtask

  // a top threshold stays quiet; lowering it under a held count fires at once
  task automatic test_hold_saturation();
    set_threshold(16'hFFFF);
    repeat (150) send_item(FUNC_TICK, 16'h0C00, 4'($urandom));
    set_threshold(LONG_PRESS_RESET);
    repeat (3) send_item(FUNC_TICK, 16'h0C00, 4'($urandom));
    tick_twice(16'h0000, 4'd0);
    send_item(FUNC_CLR_ENTER, 16'h0000, 4'd0);
    send_item(FUNC_CLR_CANCEL, 16'h0000, 4'd0);
  endtask

  function automatic logic [15:0] pick_keys(logic [15:0] held);
    logic [15:0] keys;
    case ($urandom_range(5))
      0: keys = '0;
      1: keys = 16'(1 << $urandom_range(NUM_DIGITS - 1));
      2: keys = 16'(1 << $urandom_range(KEY_CANCEL, KEY_ENTER)) | 16'($urandom_range(1)
                << $urandom_range(NUM_DIGITS - 1));
      3: keys = 16'($urandom) & 16'($urandom) & 16'h0FFF;
      4: keys = 16'($urandom);
      default: keys = held | 16'(1 << $urandom_range(KEY_CANCEL));
    endcase
    return keys;
  endfunction

  task automatic test_random_phase(int n, int gap, int stall, logic [15:0] ticks);
    int          sent;
    int          reps;
    int          roll;
    logic        paused;
    logic [15:0] keys;
    set_threshold(ticks);
    gap_pct = gap;
    stall_pct = stall;
    keys = '0;
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent >= n / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_item(func_t'($urandom_range(3, 1)), 16'($urandom), 4'($urandom));
        sent++;
      end else if (roll < 22) begin
        send_item(FUNC_TICK, 16'($urandom), 4'($urandom));
        sent++;
      end else begin
        keys = pick_keys(keys);
        reps = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
        repeat (reps) send_item(FUNC_TICK, keys, 4'($urandom));
        sent += reps;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_zero();
    test_buffer_wrap();
    test_hold_saturation();
    test_random_phase(230, 0, 0, 16'd2);
    test_random_phase(230, 76, 0, 16'd0);
    test_random_phase(230, 0, 76, 16'd5);
    test_random_phase(230, 17, 17, 16'd3);
    wait_drain();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_keypad_debounce_long_press passed");
    end else begin
      $display("tb_keypad_debounce_long_press failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_keypad_debounce_long_press failed");
    $finish;
  end

endmodule
